FILE: src/qmap_pkg.sv
// Shared types and constants for the qubit map scheduler.
`default_nettype none

package qmap_pkg;

   // Width of a qubit field on the ports
   localparam int QUBIT_W = 4;
   // Width of time and count values
   localparam int TIME_W = 16;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   // Default number of qubits
   localparam int DEFAULT_NUM_QUBITS = 16;

   // Port widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 64;

   // Action codes carried in req_tuser
   typedef enum logic [REQ_USER_W-1:0] {
      ACT_PLACE = 2'd0,
      ACT_GATE1 = 2'd1,
      ACT_GATE2 = 2'd2,
      ACT_SWAP  = 2'd3
   } action_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOCATE = 4'b0010,
      S_FIRST  = 4'b0100,
      S_LAST   = 4'b1000
   } state_type;

endpackage

`default_nettype wire

FILE: src/qmap_mem.sv
// Two-read one-write synchronous memory with per-entry valid bits for its reset value.
`default_nettype none

module qmap_mem #(
   parameter int DEPTH    = 16,
   parameter int ADDR_W   = 4,
   parameter int DATA_W   = 4,
   parameter bit IDENTITY = 1'b0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [DATA_W-1:0] rd_data_a,
   output logic      [DATA_W-1:0] rd_data_b,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] qa_ff, qb_ff;
   logic              hit_a_ff, hit_b_ff;
   logic [ADDR_W-1:0] ra_ff, rb_ff;

   // Storage and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      qa_ff    <= mem_ff[rd_addr_a];
      qb_ff    <= mem_ff[rd_addr_b];
      hit_a_ff <= valid_ff[rd_addr_a];
      hit_b_ff <= valid_ff[rd_addr_b];
      ra_ff    <= rd_addr_a;
      rb_ff    <= rd_addr_b;
   end

   // Entry written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Unwritten entries read as identity or zero
   assign rd_data_a = hit_a_ff ? qa_ff : (IDENTITY ? DATA_W'(ra_ff) : '0);
   assign rd_data_b = hit_b_ff ? qb_ff : (IDENTITY ? DATA_W'(rb_ff) : '0);

endmodule

`default_nettype wire

FILE: src/qubit_map_asap_scheduler.sv
// Top level of the qubit map scheduler: sequencer, maps, ready times and result register.
//
// Keeps a logical/physical qubit map and a ready time per physical qubit.
// Request channel (req_): req_tuser holds the action (place, one-qubit gate,
// two-qubit gate, swap); req_tdata holds the logical and physical operands.
// Response channel (rsp_): one response per request with the start time,
// locations used, qubits moved by a swap, makespan and swap count.
// Requests are taken one at a time; req_tready is high only in idle.
// Place and swap pass through the first and last steps; gates first look up
// their locations, then pass through the first and last steps; an out-of-range
// request goes straight to the last step. The next request can be taken once
// the sequencer is back in idle. The steps are set by the three state
// memories: registered reads, then one write per memory per cycle, and a gate
// must look up its location before reading that location's ready time.
// The response register decouples the sides: a request is taken while the
// last response still waits. If the receiver stalls, the sequencer holds in
// its last step until the response register frees up.
// Reset (synchronous) restores the identity map, zero ready times, zero
// makespan and count; it takes effect at once, no clearing pass.
`default_nettype none

module qubit_map_asap_scheduler
   import qmap_pkg::*;
#(
   parameter int NUM_QUBITS = DEFAULT_NUM_QUBITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [3:0] logical_first, [7:4] logical_second, [11:8] physical_first,
   // [15:12] physical_second
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] start_slot, [19:16] loc_first, [23:20] loc_second,
   // [27:24] moved_first, [31:28] moved_second, [47:32] total_span,
   // [63:48] swaps_done
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(NUM_QUBITS);

   function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] t);
      return (t == TIME_MAX) ? t : t + TIME_W'(1);
   endfunction

   function automatic logic [TIME_W-1:0] later(input logic [TIME_W-1:0] a,
                                               input logic [TIME_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic in_range(input logic [QUBIT_W-1:0] q);
      return 32'(q) < 32'(NUM_QUBITS);
   endfunction

   // Request fields
   logic [QUBIT_W-1:0] req_lq1, req_lq2, req_pq1, req_pq2;
   action_type         req_act;
   assign req_lq1 = req_tdata[3:0];
   assign req_lq2 = req_tdata[7:4];
   assign req_pq1 = req_tdata[11:8];
   assign req_pq2 = req_tdata[15:12];
   assign req_act = action_type'(req_tuser);

   state_type          state_ff, state_in;
   action_type         act_ff;
   logic [QUBIT_W-1:0] lq1_ff, pq1_ff, pq2_ff;
   logic               ok_ff;
   logic [IDX_W-1:0]   loc1_ff, loc2_ff, mv1_ff, mv2_ff;
   logic [IDX_W-1:0]   loc1_in, loc2_in, mv1_in, mv2_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic [TIME_W-1:0]  span_ff, span_in, tally_ff, tally_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_fire, out_free, finish, req_ok;

   // Memory ports
   logic [IDX_W-1:0]  wl_qa, wl_qb, who_qa, who_qb;
   logic [TIME_W-1:0] rdy_qa, rdy_qb;
   logic [IDX_W-1:0]  rdy_ra, rdy_rb;
   logic              wl_we, who_we, rdy_we;
   logic [IDX_W-1:0]  wl_wa, wl_wd, who_wa, who_wd, rdy_wa;
   logic [TIME_W-1:0] rdy_wd;

   logic [TIME_W-1:0] first_start, last_end;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign finish     = (state_ff == S_LAST) && out_free;

   // Range check of the indices that the action uses
   always_comb begin
      case (req_act)
         ACT_PLACE: req_ok = in_range(req_lq1) && in_range(req_pq1);
         ACT_GATE1: req_ok = in_range(req_lq1);
         ACT_GATE2: req_ok = in_range(req_lq1) && in_range(req_lq2);
         ACT_SWAP:  req_ok = in_range(req_pq1) && in_range(req_pq2);
         default:   req_ok = 1'b0;
      endcase
   end

   // Maps and ready times
   qmap_mem #(
      .DEPTH(NUM_QUBITS), .ADDR_W(IDX_W), .DATA_W(IDX_W), .IDENTITY(1'b1)
   ) u_where (
      .clock, .reset,
      .rd_addr_a(IDX_W'(req_lq1)), .rd_addr_b(IDX_W'(req_lq2)),
      .rd_data_a(wl_qa), .rd_data_b(wl_qb),
      .wr_en(wl_we), .wr_addr(wl_wa), .wr_data(wl_wd)
   );

   qmap_mem #(
      .DEPTH(NUM_QUBITS), .ADDR_W(IDX_W), .DATA_W(IDX_W), .IDENTITY(1'b1)
   ) u_who (
      .clock, .reset,
      .rd_addr_a(IDX_W'(req_pq1)), .rd_addr_b(IDX_W'(req_pq2)),
      .rd_data_a(who_qa), .rd_data_b(who_qb),
      .wr_en(who_we), .wr_addr(who_wa), .wr_data(who_wd)
   );

   qmap_mem #(
      .DEPTH(NUM_QUBITS), .ADDR_W(IDX_W), .DATA_W(TIME_W), .IDENTITY(1'b0)
   ) u_ready (
      .clock, .reset,
      .rd_addr_a(rdy_ra), .rd_addr_b(rdy_rb),
      .rd_data_a(rdy_qa), .rd_data_b(rdy_qb),
      .wr_en(rdy_we), .wr_addr(rdy_wa), .wr_data(rdy_wd)
   );

   // Ready-time reads: swap operands at accept, gate locations after lookup
   always_comb begin
      if (state_ff == S_LOCATE) begin
         rdy_ra = wl_qa;
         rdy_rb = (act_ff == ACT_GATE2) ? wl_qb : wl_qa;
      end else begin
         rdy_ra = IDX_W'(req_pq1);
         rdy_rb = IDX_W'(req_pq2);
      end
   end

   assign first_start = (act_ff == ACT_GATE1) ? rdy_qa : later(rdy_qa, rdy_qb);
   assign last_end    = sat_inc(start_ff);

   // Write-back: first pair of writes, then the second pair on the last step
   always_comb begin
      wl_we  = 1'b0;
      wl_wa  = '0;
      wl_wd  = '0;
      who_we = 1'b0;
      who_wa = '0;
      who_wd = '0;
      rdy_we = 1'b0;
      rdy_wa = '0;
      rdy_wd = sat_inc(first_start);
      if (state_ff == S_FIRST) begin
         case (act_ff)
            ACT_PLACE: begin
               // displaced qubit takes the location left by the placed one
               wl_we  = 1'b1;
               wl_wa  = who_qa;
               wl_wd  = wl_qa;
               who_we = 1'b1;
               who_wa = wl_qa;
               who_wd = who_qa;
            end
            ACT_GATE1, ACT_GATE2: begin
               rdy_we = 1'b1;
               rdy_wa = loc1_ff;
            end
            ACT_SWAP: begin
               rdy_we = 1'b1;
               rdy_wa = IDX_W'(pq1_ff);
               wl_we  = 1'b1;
               wl_wa  = who_qa;
               wl_wd  = IDX_W'(pq2_ff);
               who_we = 1'b1;
               who_wa = IDX_W'(pq2_ff);
               who_wd = who_qa;
            end
            default: ;
         endcase
      end else if (finish && ok_ff) begin
         rdy_wd = last_end;
         case (act_ff)
            ACT_PLACE: begin
               wl_we  = 1'b1;
               wl_wa  = IDX_W'(lq1_ff);
               wl_wd  = IDX_W'(pq1_ff);
               who_we = 1'b1;
               who_wa = IDX_W'(pq1_ff);
               who_wd = IDX_W'(lq1_ff);
            end
            ACT_GATE2: begin
               rdy_we = 1'b1;
               rdy_wa = loc2_ff;
            end
            ACT_SWAP: begin
               rdy_we = 1'b1;
               rdy_wa = IDX_W'(pq2_ff);
               wl_we  = 1'b1;
               wl_wa  = mv2_ff;
               wl_wd  = IDX_W'(pq1_ff);
               who_we = 1'b1;
               who_wa = IDX_W'(pq1_ff);
               who_wd = mv2_ff;
            end
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_ok) begin
                  state_in = S_LAST;
               end else if (req_act == ACT_GATE1 || req_act == ACT_GATE2) begin
                  state_in = S_LOCATE;
               end else begin
                  state_in = S_FIRST;
               end
            end
         end
         S_LOCATE: state_in = S_FIRST;
         S_FIRST:  state_in = S_LAST;
         S_LAST:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Working registers of the current request
   always_comb begin
      loc1_in  = loc1_ff;
      loc2_in  = loc2_ff;
      mv1_in   = mv1_ff;
      mv2_in   = mv2_ff;
      start_in = start_ff;
      if (state_ff == S_LOCATE) begin
         loc1_in = wl_qa;
         loc2_in = (act_ff == ACT_GATE2) ? wl_qb : '0;
      end else if (state_ff == S_FIRST) begin
         start_in = first_start;
         mv1_in   = who_qa;
         mv2_in   = who_qb;
         if (act_ff == ACT_PLACE) begin
            loc2_in = wl_qa;
         end
      end
   end

   // Makespan, swap count and the response
   always_comb begin
      span_in      = span_ff;
      tally_in     = tally_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (ok_ff) begin
            if (act_ff != ACT_PLACE) begin
               span_in = later(span_ff, last_end);
            end
            if (act_ff == ACT_SWAP && tally_ff != TIME_MAX) begin
               tally_in = tally_ff + TIME_W'(1);
            end
            case (act_ff)
               ACT_PLACE: begin
                  rsp_data_in[19:16] = pq1_ff;
                  rsp_data_in[23:20] = QUBIT_W'(loc2_ff);
               end
               ACT_GATE1, ACT_GATE2: begin
                  rsp_data_in[15:0]  = start_ff;
                  rsp_data_in[19:16] = QUBIT_W'(loc1_ff);
                  rsp_data_in[23:20] = QUBIT_W'(loc2_ff);
               end
               ACT_SWAP: begin
                  rsp_data_in[15:0]  = start_ff;
                  rsp_data_in[19:16] = pq1_ff;
                  rsp_data_in[23:20] = pq2_ff;
                  rsp_data_in[27:24] = QUBIT_W'(mv1_ff);
                  rsp_data_in[31:28] = QUBIT_W'(mv2_ff);
               end
               default: ;
            endcase
         end
         rsp_data_in[47:32] = span_in;
         rsp_data_in[63:48] = tally_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         span_ff      <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         span_ff      <= span_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= req_act;
         lq1_ff <= req_lq1;
         pq1_ff <= req_pq1;
         pq2_ff <= req_pq2;
         ok_ff  <= req_ok;
      end
      loc1_ff     <= loc1_in;
      loc2_ff     <= loc2_in;
      mv1_ff      <= mv1_in;
      mv2_ff      <= mv2_in;
      start_ff    <= start_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Makespan never shrinks
   a_span_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> span_ff >= $past(span_ff))
      else $error("makespan decreased");

   // Swap count moves only on the last step of a swap
   a_tally_only_swap: assert property (@(posedge clock) disable iff (reset)
      !(finish && act_ff == ACT_SWAP) |=> $stable(tally_ff))
      else $error("swap count changed outside a swap");

   // A response is loaded only from the last step
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_LAST))
      else $error("response without a finished request");

   // Reported makespan covers the reported start
   a_span_covers_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[47:32] >= rsp_data_ff[15:0])
      else $error("start later than makespan");

endmodule

`default_nettype wire
